@@ rtl/vbus_presence_detector_assert.svh @@
// assertion macros for the vbus presence detector, used by its hysteresis module
`ifndef VBUS_PRESENCE_DETECTOR_ASSERT_SVH
`define VBUS_PRESENCE_DETECTOR_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define VPD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define VPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/vpd_pkg.sv @@
// shared widths, register indexes, reset values and types of the vbus presence detector
`timescale 1ns / 1ps

package vpd_pkg;

  localparam int SAMPLES = 8;

  localparam int PIN_W      = 12;
  localparam int BUS_W      = 13;
  localparam int THR_W      = 13;
  localparam int CNT_W      = 8;
  localparam int GAIN_W     = 16;
  localparam int GAIN_FRAC  = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ON_THR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_THR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ON_REQ  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_REQ = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 3'd4;

  localparam logic [THR_W-1:0]  ON_THR_RST  = 13'd3800;
  localparam logic [THR_W-1:0]  OFF_THR_RST = 13'd3200;
  localparam logic [CNT_W-1:0]  ON_REQ_RST  = 8'd3;
  localparam logic [CNT_W-1:0]  OFF_REQ_RST = 8'd3;
  localparam logic [GAIN_W-1:0] GAIN_RST    = 16'd10426;

  localparam logic [BUS_W-1:0] BUS_MAX = 13'd6000;

  // group accumulation
  localparam int POS_W = $clog2(SAMPLES);
  localparam int SUM_W = $clog2(SAMPLES * ((1 << PIN_W) - 1) + 1);

  // trimmed sum divided by (SAMPLES - 2) through a rounded-up reciprocal
  localparam int     TRIM_DIV   = SAMPLES - 2;
  localparam int     DIV_SHIFT  = SUM_W + $clog2(TRIM_DIV);
  localparam int     DIV_MULT_W = SUM_W + 1;
  localparam longint DIV_MULT   = ((longint'(1) << DIV_SHIFT) + TRIM_DIV - 1) / TRIM_DIV;
  localparam int     QUOT_W     = SUM_W + DIV_MULT_W;

  localparam int SCALED_W = PIN_W + GAIN_W - GAIN_FRAC;

  typedef struct packed {
    logic [THR_W-1:0]  on_thr;
    logic [THR_W-1:0]  off_thr;
    logic [CNT_W-1:0]  on_req;
    logic [CNT_W-1:0]  off_req;
    logic [GAIN_W-1:0] gain;
  } cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [PIN_W-1:0] min;
    logic [PIN_W-1:0] max;
  } grp_t;

endpackage

@@ rtl/vpd_cfg.sv @@
// configuration register file of the vbus presence detector
`timescale 1ns / 1ps

module vpd_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [vpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vpd_pkg::CFG_DATA_W-1:0] cfg_data,
  output vpd_pkg::cfg_t                  cfg
);
  import vpd_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.on_thr  <= ON_THR_RST;
      cfg.off_thr <= OFF_THR_RST;
      cfg.on_req  <= ON_REQ_RST;
      cfg.off_req <= OFF_REQ_RST;
      cfg.gain    <= GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ON_THR:  cfg.on_thr  <= cfg_data[THR_W-1:0];
        REG_OFF_THR: cfg.off_thr <= cfg_data[THR_W-1:0];
        REG_ON_REQ:  cfg.on_req  <= cfg_data[CNT_W-1:0];
        REG_OFF_REQ: cfg.off_req <= cfg_data[CNT_W-1:0];
        REG_GAIN:    cfg.gain    <= cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

@@ rtl/vpd_accum.sv @@
// warm-up drop and per-group sum, minimum and maximum of the pin samples
`timescale 1ns / 1ps

module vpd_accum (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      sample_valid,
  output logic                      sample_stall,
  input  logic [vpd_pkg::PIN_W-1:0] pin_millivolts,
  output logic                      grp_valid,
  input  logic                      grp_ready,
  output vpd_pkg::grp_t             grp
);
  import vpd_pkg::*;

  logic             warmed_up;
  logic [POS_W-1:0] group_position;
  logic [SUM_W-1:0] group_sum;
  logic [PIN_W-1:0] group_min;
  logic [PIN_W-1:0] group_max;

  logic             accept;
  logic             last;
  logic [SUM_W-1:0] group_sum_next;
  logic [PIN_W-1:0] group_min_next;
  logic [PIN_W-1:0] group_max_next;

  // hold off only while a finished group cannot move on
  assign sample_stall = grp_valid && !grp_ready;
  assign accept       = sample_valid && !sample_stall;
  assign last         = (group_position == POS_W'(SAMPLES - 1));

  assign group_sum_next = group_sum + SUM_W'(pin_millivolts);
  assign group_min_next = (pin_millivolts < group_min) ? pin_millivolts : group_min;
  assign group_max_next = (pin_millivolts > group_max) ? pin_millivolts : group_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      warmed_up      <= 1'b0;
      group_position <= '0;
      group_sum      <= '0;
      group_min      <= '1;
      group_max      <= '0;
      grp_valid      <= 1'b0;
    end else begin
      if (accept && warmed_up && last) begin
        grp_valid <= 1'b1;
      end else if (grp_ready) begin
        grp_valid <= 1'b0;
      end
      if (accept) begin
        if (!warmed_up) begin
          warmed_up <= 1'b1;
        end else if (last) begin
          grp.sum        <= group_sum_next;
          grp.min        <= group_min_next;
          grp.max        <= group_max_next;
          group_position <= '0;
          group_sum      <= '0;
          group_min      <= '1;
          group_max      <= '0;
        end else begin
          group_position <= group_position + 1'b1;
          group_sum      <= group_sum_next;
          group_min      <= group_min_next;
          group_max      <= group_max_next;
        end
      end
    end
  end

endmodule

@@ rtl/vpd_scale.sv @@
// trimmed mean by reciprocal multiply, then divider gain scaling, two register stages
`timescale 1ns / 1ps

module vpd_scale (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         grp_valid,
  output logic                         grp_ready,
  input  vpd_pkg::grp_t                grp,
  input  logic [vpd_pkg::GAIN_W-1:0]   gain,
  output logic                         sc_valid,
  input  logic                         sc_ready,
  output logic [vpd_pkg::SCALED_W-1:0] sc_value
);
  import vpd_pkg::*;

  localparam int PROD_W = PIN_W + GAIN_W;
  localparam logic [DIV_MULT_W-1:0] DIV_MULT_C = DIV_MULT_W'(DIV_MULT);

  logic             mean_valid;
  logic [PIN_W-1:0] mean;

  logic              mean_free;
  logic              sc_free;
  logic [SUM_W-1:0]  trimmed;
  logic [QUOT_W-1:0] quot;
  logic [PROD_W-1:0] prod;

  assign sc_free   = !sc_valid || sc_ready;
  assign mean_free = !mean_valid || sc_free;
  assign grp_ready = mean_free;

  // the sum holds both extremes, so this never wraps
  assign trimmed = grp.sum - SUM_W'(grp.min) - SUM_W'(grp.max);
  assign quot    = QUOT_W'(trimmed) * QUOT_W'(DIV_MULT_C);
  assign prod    = PROD_W'(mean) * PROD_W'(gain);

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_valid <= 1'b0;
      sc_valid   <= 1'b0;
    end else begin
      if (mean_free) begin
        mean_valid <= grp_valid;
      end
      if (sc_free) begin
        sc_valid <= mean_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mean_free && grp_valid) begin
      mean <= quot[DIV_SHIFT +: PIN_W];
    end
    if (sc_free && mean_valid) begin
      sc_value <= prod[GAIN_FRAC +: SCALED_W];
    end
  end

endmodule

@@ rtl/vpd_hyst.sv @@
// clamp, hysteresis with run-count debouncing and the result register
`timescale 1ns / 1ps

module vpd_hyst (
  input  logic                         clk,
  input  logic                         rst,
  input  vpd_pkg::cfg_t                cfg,
  input  logic                         sc_valid,
  output logic                         sc_ready,
  input  logic [vpd_pkg::SCALED_W-1:0] sc_value,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic                         usb_present,
  output logic [vpd_pkg::BUS_W-1:0]    bus_millivolts,
  output logic                         presence_changed
);
  import vpd_pkg::*;

  `include "vbus_presence_detector_assert.svh"

  logic [CNT_W-1:0] high_run_count;
  logic [CNT_W-1:0] low_run_count;
  logic             present_flag;

  logic [CNT_W-1:0] high_run_count_next;
  logic [CNT_W-1:0] low_run_count_next;
  logic             present_flag_next;
  logic             load;
  logic [BUS_W-1:0] bus;
  logic             is_high;
  logic             is_low;

  function automatic logic [CNT_W-1:0] bump_run(input logic [CNT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  assign sc_ready = !result_valid || !result_stall;
  assign load     = sc_valid && sc_ready;

  assign bus = (sc_value > {{(SCALED_W - BUS_W){1'b0}}, BUS_MAX}) ? BUS_MAX
                                                                  : sc_value[BUS_W-1:0];
  assign is_high = (bus >= cfg.on_thr);
  assign is_low  = (bus <= cfg.off_thr);

  always_comb begin
    high_run_count_next = high_run_count;
    low_run_count_next  = low_run_count;
    present_flag_next   = present_flag;
    if (!present_flag) begin
      if (is_high) begin
        high_run_count_next = bump_run(high_run_count);
        if (high_run_count_next >= cfg.on_req) begin
          present_flag_next  = 1'b1;
          low_run_count_next = '0;
        end
      end else begin
        high_run_count_next = '0;
      end
    end else begin
      if (is_low) begin
        low_run_count_next = bump_run(low_run_count);
        if (low_run_count_next >= cfg.off_req) begin
          present_flag_next   = 1'b0;
          high_run_count_next = '0;
        end
      end else begin
        low_run_count_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid   <= 1'b0;
      high_run_count <= '0;
      low_run_count  <= '0;
      present_flag   <= 1'b0;
    end else begin
      if (sc_ready) begin
        result_valid <= sc_valid;
      end
      if (load) begin
        high_run_count <= high_run_count_next;
        low_run_count  <= low_run_count_next;
        present_flag   <= present_flag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      usb_present      <= present_flag_next;
      bus_millivolts   <= bus;
      presence_changed <= present_flag_next != present_flag;
    end
  end

  `VPD_ASSERT_NEXT(a_load_gives_word, clk, rst, load, result_valid,
                   "loaded result word not shown")
  `VPD_ASSERT_NEXT(a_flag_moves_on_load, clk, rst, !load, $stable(present_flag),
                   "presence flag changed without a group")
  `VPD_ASSERT_NEXT(a_changed_matches_flag, clk, rst, load,
                   presence_changed == (present_flag != $past(present_flag)),
                   "presence_changed disagrees with the flag")
  `VPD_ASSERT_SAME(a_bus_clamped, clk, rst, result_valid, bus_millivolts <= BUS_MAX,
                   "bus voltage above clamp")

endmodule

@@ rtl/vbus_presence_detector.sv @@
// vbus presence detector top level: one result word per completed sample group
// a group's last sample reaches its word via group, mean, scale and result registers
// throughput: one sample per cycle while not stalled; one result per SAMPLES samples,
//   the first group taking one extra sample for the dropped warm-up read
// the two multiplies (reciprocal divide and divider gain) each sit in a register stage
// reset (rst, synchronous): clears group, run counts and flag; registers take defaults
`timescale 1ns / 1ps

module vbus_presence_detector (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           sample_valid,
  output logic                           sample_stall,
  input  logic [vpd_pkg::PIN_W-1:0]      pin_millivolts,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic                           usb_present,
  output logic [vpd_pkg::BUS_W-1:0]      bus_millivolts,
  output logic                           presence_changed,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [vpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vpd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import vpd_pkg::*;

  cfg_t                cfg;
  grp_t                grp;
  logic                grp_valid;
  logic                grp_ready;
  logic                sc_valid;
  logic                sc_ready;
  logic [SCALED_W-1:0] sc_value;

  vpd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  vpd_accum u_accum (
    .clk            (clk),
    .rst            (rst),
    .sample_valid   (sample_valid),
    .sample_stall   (sample_stall),
    .pin_millivolts (pin_millivolts),
    .grp_valid      (grp_valid),
    .grp_ready      (grp_ready),
    .grp            (grp)
  );

  vpd_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .grp_valid (grp_valid),
    .grp_ready (grp_ready),
    .grp       (grp),
    .gain      (cfg.gain),
    .sc_valid  (sc_valid),
    .sc_ready  (sc_ready),
    .sc_value  (sc_value)
  );

  vpd_hyst u_hyst (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .sc_valid         (sc_valid),
    .sc_ready         (sc_ready),
    .sc_value         (sc_value),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .usb_present      (usb_present),
    .bus_millivolts   (bus_millivolts),
    .presence_changed (presence_changed)
  );

endmodule

@@ dv/vbus_presence_detector_test.sv @@
// self-checking testbench for the vbus presence detector: directed groups, then random phases
`timescale 1ns / 1ps

module vbus_presence_detector_test;
  import vpd_pkg::*;

  localparam int          PIN_TOP       = (1 << PIN_W) - 1;
  localparam int          SETTLE_CYCLES = 12;
  localparam int          TAIL_CYCLES   = 16;
  localparam int          DRAIN_LIMIT   = 20000;
  localparam int unsigned RUN_LIMIT     = 500000;
  localparam int          DIR_ROWS      = 4;
  localparam int          PHASES        = 6;

  typedef struct packed {
    logic             present;
    logic [BUS_W-1:0] bus;
    logic             changed;
  } report_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  sample_valid = 1'b0;
  logic                  sample_stall;
  logic [PIN_W-1:0]      pin_millivolts = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic                  usb_present;
  logic [BUS_W-1:0]      bus_millivolts;
  logic                  presence_changed;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  vbus_presence_detector dut (
    .clk              (clk),
    .rst              (rst),
    .sample_valid     (sample_valid),
    .sample_stall     (sample_stall),
    .pin_millivolts   (pin_millivolts),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .usb_present      (usb_present),
    .bus_millivolts   (bus_millivolts),
    .presence_changed (presence_changed),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  // shadow of the register file and of the detector state
  cfg_t             shadow_cfg = {ON_THR_RST, OFF_THR_RST, ON_REQ_RST, OFF_REQ_RST, GAIN_RST};
  logic             warm = 1'b0;
  int unsigned      grp_pos = 0;
  logic [16:0]      grp_sum = '0;
  logic [PIN_W-1:0] grp_min = '1;
  logic [PIN_W-1:0] grp_max = '0;
  logic [CNT_W-1:0] high_run = '0;
  logic [CNT_W-1:0] low_run = '0;
  logic             present = 1'b0;

  report_t     expected_reports[$];
  int          errors = 0;
  int          burst_left = 0;
  int unsigned cycles_run = 0;

  // directed groups: min at position 2, max at position 5, body elsewhere
  int unsigned      dir_len   [DIR_ROWS] = '{1, SAMPLES, SAMPLES, SAMPLES};
  logic [PIN_W-1:0] dir_lo    [DIR_ROWS] = '{'1, '0, '1, '0};
  logic [PIN_W-1:0] dir_hi    [DIR_ROWS] = '{'1, '0, '1, '1};
  logic [PIN_W-1:0] dir_body  [DIR_ROWS] = '{'1, '0, '1, 1493};
  bit               dir_typed [DIR_ROWS] = '{1'b0, 1'b1, 1'b1, 1'b0};
  report_t          dir_want  [DIR_ROWS] = '{'0, '0, {1'b0, BUS_MAX, 1'b0}, '0};

  logic [CFG_DATA_W-1:0] ph_on [PHASES] =
    '{16'd3000, 16'd0, 16'hFFFF, 16'd0, 16'd2500, CFG_DATA_W'(ON_THR_RST)};
  logic [CFG_DATA_W-1:0] ph_off [PHASES] =
    '{16'd2000, 16'd6000, 16'hFFFF, 16'h1FFF, 16'd2600, CFG_DATA_W'(OFF_THR_RST)};
  logic [CFG_DATA_W-1:0] ph_on_req [PHASES] =
    '{16'd1, 16'd0, 16'hFF02, 16'd255, 16'd4, CFG_DATA_W'(ON_REQ_RST)};
  logic [CFG_DATA_W-1:0] ph_off_req [PHASES] =
    '{16'd1, 16'd0, 16'h1F05, 16'd255, 16'd2, CFG_DATA_W'(OFF_REQ_RST)};
  logic [CFG_DATA_W-1:0] ph_gain [PHASES] =
    '{16'd16384, 16'hFFFF, 16'd0, CFG_DATA_W'(GAIN_RST), 16'd8192, CFG_DATA_W'(GAIN_RST)};
  int ph_groups [PHASES] = '{12, 10, 8, 32, 15, 12};
  bit ph_noise  [PHASES] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};

  // folds one accepted sample into the group; returns 1 when a group completes
  function automatic bit track_sample(input logic [PIN_W-1:0] v, output report_t r);
    int unsigned mean;
    int unsigned scaled;
    logic        was;
    r = '0;
    if (!warm) begin
      warm = 1'b1;
      return 1'b0;
    end
    grp_sum = grp_sum + v;
    if (v < grp_min) grp_min = v;
    if (v > grp_max) grp_max = v;
    if (grp_pos + 1 < SAMPLES) begin
      grp_pos++;
      return 1'b0;
    end
    mean   = (grp_sum - grp_min - grp_max) / (SAMPLES - 2);
    scaled = (mean * shadow_cfg.gain) >> GAIN_FRAC;
    if (scaled > BUS_MAX) scaled = BUS_MAX;
    grp_pos = 0;
    grp_sum = '0;
    grp_min = '1;
    grp_max = '0;
    was = present;
    if (!present) begin
      if (scaled >= shadow_cfg.on_thr) begin
        if (high_run != '1) high_run++;
        if (high_run >= shadow_cfg.on_req) begin
          present = 1'b1;
          low_run = '0;
        end
      end else begin
        high_run = '0;
      end
    end else begin
      if (scaled <= shadow_cfg.off_thr) begin
        if (low_run != '1) low_run++;
        if (low_run >= shadow_cfg.off_req) begin
          present  = 1'b0;
          high_run = '0;
        end
      end else begin
        low_run = '0;
      end
    end
    r.present = present;
    r.bus     = scaled[BUS_W-1:0];
    r.changed = present != was;
    return 1'b1;
  endfunction

  function automatic int clip_pin(input int x);
    if (x < 0) return 0;
    if (x > PIN_TOP) return PIN_TOP;
    return x;
  endfunction

  // pin level whose trimmed mean lands near a bus threshold
  function automatic int near_threshold(input logic [THR_W-1:0] thr);
    int unsigned t;
    if (shadow_cfg.gain == 0) return $urandom_range(0, PIN_TOP);
    t = (thr * 4096 + shadow_cfg.gain - 1) / shadow_cfg.gain;
    return clip_pin(int'(t) + int'($urandom_range(0, 4)) - 2);
  endfunction

  function automatic int pick_level();
    case ($urandom_range(0, 3))
      0:       return near_threshold(shadow_cfg.on_thr);
      1:       return near_threshold(shadow_cfg.off_thr);
      2:       return $urandom_range(0, PIN_TOP);
      default: return ($urandom_range(0, 1) == 0) ? 0 : PIN_TOP;
    endcase
  endfunction

  task automatic note_error(input string what, input int want, input int got);
    errors++;
    if (errors <= 10)
      $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
  endtask

  task automatic push_sample(input logic [PIN_W-1:0] v, input bit typed, input report_t want);
    report_t r;
    int      gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        sample_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    sample_valid   <= 1'b1;
    pin_millivolts <= v;
    do @(posedge clk); while (sample_stall);
    burst_left--;
    if (track_sample(v, r)) begin
      if (typed) r = want;
      expected_reports.push_back(r);
    end
  endtask

  // groups held at a level for a few groups in a row, with outliers and stray words
  task automatic run_groups(input int groups, input bit noise_only);
    int level;
    int spread;
    int run_left;
    int g;
    int k;
    int s;
    run_left = 0;
    level    = 0;
    spread   = 0;
    for (g = 0; g < groups; g++) begin
      if (run_left == 0) begin
        level    = pick_level();
        spread   = $urandom_range(0, 3);
        run_left = $urandom_range(1, 6);
      end
      run_left--;
      for (k = 0; k < SAMPLES; k++) begin
        if (noise_only || $urandom_range(0, 7) == 0)
          s = $urandom_range(0, PIN_TOP);
        else
          s = clip_pin(level + int'($urandom_range(0, 2 * spread)) - spread);
        push_sample(s[PIN_W-1:0], 1'b0, '0);
      end
      // broken sequence: a few extra words shift the group boundary
      if ($urandom_range(0, 15) == 0)
        repeat ($urandom_range(1, SAMPLES - 1))
          push_sample(PIN_W'($urandom_range(0, PIN_TOP)), 1'b0, '0);
    end
  endtask

  task automatic settle();
    @(negedge clk) sample_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ON_THR:  shadow_cfg.on_thr  = data[THR_W-1:0];
      REG_OFF_THR: shadow_cfg.off_thr = data[THR_W-1:0];
      REG_ON_REQ:  shadow_cfg.on_req  = data[CNT_W-1:0];
      REG_OFF_REQ: shadow_cfg.off_req = data[CNT_W-1:0];
      REG_GAIN:    shadow_cfg.gain    = data[GAIN_W-1:0];
      default: ;
    endcase
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // result side stalls in randomly chosen modes: none, light, heavy or periodic
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;
  int unsigned stall_tick = 0;

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 120);
    end else begin
      stall_left--;
    end
    stall_tick++;
    case (stall_mode)
      STALL_NONE:  result_stall <= 1'b0;
      STALL_LIGHT: result_stall <= ($urandom_range(0, 2) == 0);
      STALL_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
      default:     result_stall <= (stall_tick % 7) < 3;
    endcase
  end

  always @(posedge clk) begin
    report_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_reports.size() == 0) begin
        note_error("unexpected result word, bus_millivolts", -1, bus_millivolts);
      end else begin
        want = expected_reports.pop_front();
        if (usb_present !== want.present)
          note_error("usb_present", want.present, usb_present);
        if (bus_millivolts !== want.bus)
          note_error("bus_millivolts", want.bus, bus_millivolts);
        if (presence_changed !== want.changed)
          note_error("presence_changed", want.changed, presence_changed);
      end
    end
  end

  always @(posedge clk) begin
    cycles_run++;
    if (cycles_run == RUN_LIMIT) begin
      $display("vbus_presence_detector_test: errors");
      $finish;
    end
  end

  initial begin
    int row;
    int k;
    int p;
    int waited;
    logic [PIN_W-1:0] v;

    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // warm-up word, then groups at the field extremes and at the on threshold
    for (row = 0; row < DIR_ROWS; row++) begin
      for (k = 0; k < int'(dir_len[row]); k++) begin
        v = (k == 2) ? dir_lo[row] : (k == 5) ? dir_hi[row] : dir_body[row];
        push_sample(v, dir_typed[row] && (k == int'(dir_len[row]) - 1), dir_want[row]);
      end
    end

    run_groups(20, 1'b0);

    for (p = 0; p < PHASES; p++) begin
      settle();
      write_reg(REG_ON_THR, ph_on[p]);
      write_reg(REG_OFF_THR, ph_off[p]);
      write_reg(REG_ON_REQ, ph_on_req[p]);
      write_reg(REG_OFF_REQ, ph_off_req[p]);
      write_reg(REG_GAIN, ph_gain[p]);
      // index past the register file must leave everything alone
      if (p == 0)
        write_reg(CFG_IDX_W'(int'(REG_GAIN) + 1 + int'($urandom_range(0, 2))),
                  CFG_DATA_W'($urandom_range(0, 65535)));
      run_groups(ph_groups[p], ph_noise[p]);
    end

    @(negedge clk) sample_valid <= 1'b0;
    for (waited = 0; waited < DRAIN_LIMIT && expected_reports.size() != 0; waited++)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    while (expected_reports.size() != 0) begin
      void'(expected_reports.pop_front());
      note_error("missing result word, pending", 1, 0);
    end

    if (errors == 0)
      $display("vbus_presence_detector_test: clean");
    else
      $display("vbus_presence_detector_test: errors");
    $finish;
  end

endmodule
